### rtl/spta_pkg.sv
// Package for the sparse polynomial term accumulator.
// Field widths, command and status codes, the result record and the saturating add.
// No dependencies.
package spta_pkg;

	localparam int CMD_W     = 2;
	localparam int EXP_W     = 16;
	localparam int COEF_W    = 32;
	localparam int RPOS_W    = 6;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 7;
	localparam int ENTRY_W   = EXP_W + COEF_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_DEL   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_TERM = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_BEYOND  = 2'd3
	} status_t;

	typedef struct packed {
		status_t                   status;
		logic [CNT_OUT_W-1:0]      count_now;
		logic [EXP_W-1:0]          read_exponent;
		logic signed [COEF_W-1:0]  read_coefficient;
	} result_t;

	// Signed 32-bit add, clamped to the nearest limit on overflow.
	function automatic logic signed [COEF_W-1:0] sat_add(
		input logic signed [COEF_W-1:0] a,
		input logic signed [COEF_W-1:0] b
	);
		logic signed [COEF_W:0] s;
		s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
		if (s[COEF_W] != s[COEF_W-1]) begin
			if (s[COEF_W]) begin
				return {1'b1, {(COEF_W-1){1'b0}}};
			end else begin
				return {1'b0, {(COEF_W-1){1'b1}}};
			end
		end
		return s[COEF_W-1:0];
	endfunction

endpackage

### rtl/spta_if.sv
// Request and result channel interfaces of the term accumulator.
// Depends on spta_pkg for field widths.
interface spta_in_if;
	import spta_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic [EXP_W-1:0]          term_exponent;
	logic signed [COEF_W-1:0]  term_coefficient;
	logic [RPOS_W-1:0]         read_position;

	modport source (output valid, cmd, term_exponent, term_coefficient, read_position,
		input ready);
	modport sink (input valid, cmd, term_exponent, term_coefficient, read_position,
		output ready);
endinterface

interface spta_out_if;
	import spta_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STAT_W-1:0]         status;
	logic [CNT_OUT_W-1:0]      count_now;
	logic [EXP_W-1:0]          read_exponent;
	logic signed [COEF_W-1:0]  read_coefficient;

	modport source (output valid, status, count_now, read_exponent, read_coefficient,
		input ready);
	modport sink (input valid, status, count_now, read_exponent, read_coefficient,
		output ready);
endinterface

### rtl/spta_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module spta_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/spta_out_stage.sv
// Result register of the term accumulator: holds one result until the sink takes it.
// Depends on spta_pkg and spta_out_if.
module spta_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  spta_pkg::result_t res,
	output logic              free,
	spta_out_if.source        result
);
	import spta_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result.valid            = valid_q;
	assign result.status           = res_q.status;
	assign result.count_now        = res_q.count_now;
	assign result.read_exponent    = res_q.read_exponent;
	assign result.read_coefficient = res_q.read_coefficient;

endmodule

### rtl/sparse_poly_term_accumulator.sv
// Top level: sorted (exponent, coefficient) term table held in one RAM, with sequencer.
// Depends on spta_pkg, spta_if, spta_ram and spta_out_stage.
//
//  channel   | dir | payload
//  ----------+-----+---------------------------------------------------------------
//  request   | in  | cmd, term_exponent, term_coefficient, read_position
//  result    | out | status, count_now, read_exponent, read_coefficient
//
// One request at a time. Clear and zero-coefficient add go straight to S_RESP; an
// in-range read waits in S_RD_WAIT. Add and delete run a binary search, a RAM read
// and a compare per probe, for about log2(count)+1 probes, then check the term and
// respond. An insert or removal moves each following term with a read and a write
// over the single RAM read and write port pair, so the worst case grows with
// MAX_TERMS. After arst_n the table is empty; no clearing pass is needed.
// A stalled result holds the sequencer in S_RESP, request ready low, until taken.
module sparse_poly_term_accumulator #(
	parameter int MAX_TERMS = 64
) (
	input logic         clk,
	input logic         arst_n,
	spta_in_if.sink     request,
	spta_out_if.source  result
);
	import spta_pkg::*;

	localparam int AW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int XW = CW + RPOS_W;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_SRCH_RD  = 11'b000_0000_0010,
		S_SRCH_CMP = 11'b000_0000_0100,
		S_CHK_CMP  = 11'b000_0000_1000,
		S_MISS     = 11'b000_0001_0000,
		S_INS_RD   = 11'b000_0010_0000,
		S_INS_WR   = 11'b000_0100_0000,
		S_REM_RD   = 11'b000_1000_0000,
		S_REM_WR   = 11'b001_0000_0000,
		S_RD_WAIT  = 11'b010_0000_0000,
		S_RESP     = 11'b100_0000_0000
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [EXP_W-1:0]         exp_q;
	logic signed [COEF_W-1:0] coef_q;
	logic [CW-1:0]            lo_q;
	logic [CW-1:0]            hi_q;
	logic [CW-1:0]            idx_q;
	logic [CW-1:0]            count_q;
	status_t                  status_q;
	logic [EXP_W-1:0]         rexp_q;
	logic signed [COEF_W-1:0] rcoef_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [ENTRY_W-1:0]       ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic [EXP_W-1:0]         rd_exp;
	logic signed [COEF_W-1:0] rd_coef;

	logic                     accept;
	cmd_t                     in_cmd;
	logic [XW-1:0]            rpos_x;
	logic                     rpos_ok;
	logic [CW:0]              mid_sum;
	logic [CW-1:0]            mid;
	logic [CW-1:0]            idx_inc;
	logic [CW-1:0]            idx_dec;
	logic signed [COEF_W-1:0] merged;
	logic [CW+CNT_OUT_W-1:0]  count_x;
	logic                     res_load;
	logic                     out_free;
	result_t                  res;

	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;
	assign in_cmd        = cmd_t'(request.cmd);
	assign rpos_x        = XW'(request.read_position);
	assign rpos_ok       = rpos_x < XW'(count_q);

	assign rd_exp  = ram_rdata[ENTRY_W-1:COEF_W];
	assign rd_coef = ram_rdata[COEF_W-1:0];

	// Probe midpoint of the half-open window [lo, hi).
	assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
	assign mid     = mid_sum[CW:1];
	assign idx_inc = idx_q + 1'b1;
	assign idx_dec = idx_q - 1'b1;
	assign merged  = sat_add(rd_coef, coef_q);

	// RAM port control per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		res_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				ram_raddr = rpos_x[AW-1:0];
			end
			S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					ram_raddr = mid[AW-1:0];
				end else begin
					ram_raddr = lo_q[AW-1:0];
				end
			end
			S_CHK_CMP: begin
				if (rd_exp == exp_q && cmd_q == CMD_ADD && merged != '0) begin
					ram_we    = 1'b1;
					ram_waddr = lo_q[AW-1:0];
					ram_wdata = {exp_q, merged};
				end
			end
			S_INS_RD: begin
				if (idx_q > lo_q) begin
					ram_raddr = idx_dec[AW-1:0];
				end else begin
					ram_we    = 1'b1;
					ram_waddr = lo_q[AW-1:0];
					ram_wdata = {exp_q, coef_q};
				end
			end
			S_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_REM_RD: begin
				ram_raddr = idx_inc[AW-1:0];
			end
			S_REM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_RESP: begin
				res_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
							end
							CMD_READ: begin
								state_q <= rpos_ok ? S_RD_WAIT : S_RESP;
							end
							default: begin
								// add with a zero coefficient leaves the table alone
								if (in_cmd == CMD_ADD && request.term_coefficient == '0) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_SRCH_RD;
								end
							end
						endcase
					end
				end
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						state_q <= S_SRCH_CMP;
					end else if (lo_q < count_q) begin
						state_q <= S_CHK_CMP;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_SRCH_CMP: begin
					state_q <= S_SRCH_RD;
				end
				S_CHK_CMP: begin
					if (rd_exp != exp_q) begin
						state_q <= S_MISS;
					end else if (cmd_q == CMD_ADD && merged != '0) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_REM_RD;
					end
				end
				S_MISS: begin
					if (cmd_q == CMD_ADD && count_q < CW'(MAX_TERMS)) begin
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_INS_RD: begin
					if (idx_q > lo_q) begin
						state_q <= S_INS_WR;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESP;
					end
				end
				S_INS_WR: begin
					state_q <= S_INS_RD;
				end
				S_REM_RD: begin
					if (idx_inc < count_q) begin
						state_q <= S_REM_WR;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_REM_WR: begin
					state_q <= S_REM_RD;
				end
				S_RD_WAIT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q    <= in_cmd;
					exp_q    <= request.term_exponent;
					coef_q   <= request.term_coefficient;
					lo_q     <= '0;
					hi_q     <= count_q;
					rexp_q   <= '0;
					rcoef_q  <= '0;
					status_q <= (in_cmd == CMD_READ && !rpos_ok) ? STAT_BEYOND : STAT_OK;
				end
			end
			S_SRCH_CMP: begin
				if (rd_exp < exp_q) begin
					lo_q <= mid + 1'b1;
				end else begin
					hi_q <= mid;
				end
			end
			S_CHK_CMP: begin
				idx_q <= lo_q;
			end
			S_MISS: begin
				idx_q <= count_q;
				if (cmd_q == CMD_DEL) begin
					status_q <= STAT_NO_TERM;
				end else if (count_q >= CW'(MAX_TERMS)) begin
					status_q <= STAT_FULL;
				end
			end
			S_INS_WR: begin
				idx_q <= idx_dec;
			end
			S_REM_WR: begin
				idx_q <= idx_inc;
			end
			S_RD_WAIT: begin
				rexp_q  <= rd_exp;
				rcoef_q <= rd_coef;
			end
			default: begin
			end
		endcase
	end

	assign count_x              = (CW+CNT_OUT_W)'(count_q);
	assign res.status           = status_q;
	assign res.count_now        = count_x[CNT_OUT_W-1:0];
	assign res.read_exponent    = rexp_q;
	assign res.read_coefficient = rcoef_q;

	spta_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_TERMS)
	) u_term_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	spta_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_load),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TERMS))
		else $error("term count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
		else $error("term count grew by more than one");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (XW'(ram_waddr) <= XW'(count_q)))
		else $error("table write past the end of the stored terms");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted request did not start work");
`endif

endmodule

### tb/tb_sparse_poly_term_accumulator.sv
`timescale 1ns / 1ps
// Testbench for sparse_poly_term_accumulator: directed and random term requests are
// checked against an in-bench model of the sorted exponent/coefficient table.
// Depends on spta_pkg, spta_if and the RTL top level.
module tb_sparse_poly_term_accumulator;
	import spta_pkg::*;

	localparam int TERM_SLOTS   = 64;
	localparam int ITEM_TARGET  = 1600;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS  = 10;
	localparam int POOL_DEPTH   = 96;
	localparam longint COEF_MAX = 64'sd2147483647;
	localparam longint COEF_MIN = -COEF_MAX - 1;

	typedef struct packed {
		cmd_t                     cmd;
		logic [EXP_W-1:0]         exponent;
		logic signed [COEF_W-1:0] coefficient;
		logic [RPOS_W-1:0]        position;
	} term_req_t;

	logic clk;
	logic arst_n;

	spta_in_if  req_if();
	spta_out_if res_if();

	sparse_poly_term_accumulator #(
		.MAX_TERMS(TERM_SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_if),
		.result  (res_if)
	);

	// Model of the term table, kept sorted by ascending exponent.
	logic [EXP_W-1:0]         table_exp[TERM_SLOTS];
	logic signed [COEF_W-1:0] table_coef[TERM_SLOTS];
	int                       table_count;

	term_req_t        pending_requests[$];
	result_t          expected_results[$];
	logic [EXP_W-1:0] used_exponents[$];

	int        requests_total;
	int        requests_sent;
	int        results_seen;
	int        fail_count;
	int        idle_cycles;
	int        send_wait;
	int        stall_wait;
	int        stall_draw;
	term_req_t next_req;
	term_req_t seen_req;
	result_t   want;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic int lower_slot(logic [EXP_W-1:0] e);
		int i;
		i = 0;
		while (i < table_count && table_exp[i] < e) begin
			i++;
		end
		return i;
	endfunction

	function automatic void drop_slot(int pos);
		int i;
		for (i = pos; i + 1 < table_count; i++) begin
			table_exp[i]  = table_exp[i + 1];
			table_coef[i] = table_coef[i + 1];
		end
		table_count--;
	endfunction

	function automatic result_t apply_term_request(term_req_t rq);
		result_t r;
		int      pos;
		int      i;
		longint  sum;
		logic    hit;
		r        = '0;
		r.status = STAT_OK;
		pos      = lower_slot(rq.exponent);
		hit      = (pos < table_count) && (table_exp[pos] == rq.exponent);
		case (rq.cmd)
			CMD_ADD: begin
				// A zero coefficient leaves the table alone.
				if (rq.coefficient != 0) begin
					if (hit) begin
						sum = longint'(table_coef[pos]) + longint'(rq.coefficient);
						if (sum > COEF_MAX) begin
							sum = COEF_MAX;
						end else if (sum < COEF_MIN) begin
							sum = COEF_MIN;
						end
						if (sum == 0) begin
							drop_slot(pos);
						end else begin
							table_coef[pos] = sum[COEF_W-1:0];
						end
					end else if (table_count >= TERM_SLOTS) begin
						r.status = STAT_FULL;
					end else begin
						for (i = table_count; i > pos; i--) begin
							table_exp[i]  = table_exp[i - 1];
							table_coef[i] = table_coef[i - 1];
						end
						table_exp[pos]  = rq.exponent;
						table_coef[pos] = rq.coefficient;
						table_count++;
					end
				end
			end
			CMD_DEL: begin
				if (hit) begin
					drop_slot(pos);
				end else begin
					r.status = STAT_NO_TERM;
				end
			end
			CMD_READ: begin
				if (int'(rq.position) < table_count) begin
					r.read_exponent    = table_exp[rq.position];
					r.read_coefficient = table_coef[rq.position];
				end else begin
					r.status = STAT_BEYOND;
				end
			end
			CMD_CLEAR: begin
				table_count = 0;
			end
			default: begin
			end
		endcase
		r.count_now = table_count[CNT_OUT_W-1:0];
		return r;
	endfunction

	// Keep the first stretch of every 384 handshakes free of idling.
	function automatic int pick_wait(int seq);
		if ((seq / 128) % 3 == 0) begin
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic logic signed [COEF_W-1:0] draw_coefficient();
		case ($urandom_range(0, 7))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return COEF_W'($signed($urandom_range(0, 20)) - 10);
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [EXP_W-1:0] known_exponent();
		if (used_exponents.size() == 0) begin
			return EXP_W'($urandom);
		end
		return used_exponents[$urandom_range(0, used_exponents.size() - 1)];
	endfunction

	task automatic queue_request(cmd_t c, logic [EXP_W-1:0] e, logic signed [COEF_W-1:0] k,
		logic [RPOS_W-1:0] p);
		term_req_t rq;
		rq = '{cmd: c, exponent: e, coefficient: k, position: p};
		pending_requests.push_back(rq);
		if (c == CMD_ADD && k != 0) begin
			used_exponents.push_back(e);
			if (used_exponents.size() > POOL_DEPTH) begin
				void'(used_exponents.pop_front());
			end
		end
	endtask

	initial begin
		int                       pick;
		int                       p;
		logic [EXP_W-1:0]         e;
		logic signed [COEF_W-1:0] k;

		// Empty table: read beyond count, delete absent, ignored zero add.
		queue_request(CMD_READ, 16'd0, 32'sd0, 6'd0);
		queue_request(CMD_DEL, 16'd0, 32'sd0, 6'd0);
		queue_request(CMD_ADD, 16'd100, 32'sd0, 6'd0);
		queue_request(CMD_ADD, 16'hFFFF, 32'sh7FFF_FFFF, 6'd63);
		queue_request(CMD_ADD, 16'd0, 32'sh8000_0000, 6'd0);
		queue_request(CMD_ADD, 16'd100, 32'sd5, 6'd0);
		// Saturate both ways, then cancel a term to zero.
		queue_request(CMD_ADD, 16'hFFFF, 32'sd1, 6'd0);
		queue_request(CMD_ADD, 16'd0, -32'sd1, 6'd0);
		queue_request(CMD_ADD, 16'd100, -32'sd5, 6'd0);
		queue_request(CMD_READ, 16'hFFFF, 32'sh7FFF_FFFF, 6'd0);
		queue_request(CMD_READ, 16'd0, 32'sd0, 6'd1);
		queue_request(CMD_READ, 16'd0, 32'sd0, 6'd2);
		queue_request(CMD_READ, 16'd0, 32'sd0, 6'd63);
		queue_request(CMD_ADD, 16'd40000, -32'sd7, 6'd0);
		queue_request(CMD_DEL, 16'hFFFF, 32'sd0, 6'd0);
		queue_request(CMD_DEL, 16'hFFFF, 32'sd0, 6'd0);
		queue_request(CMD_ADD, 16'd0, 32'sh7FFF_FFFF, 6'd0);
		queue_request(CMD_READ, 16'd0, 32'sd0, 6'd0);
		queue_request(CMD_ADD, 16'd0, 32'sd1, 6'd0);
		queue_request(CMD_READ, 16'd0, 32'sd0, 6'd0);
		queue_request(CMD_CLEAR, 16'hFFFF, 32'shFFFF_FFFF, 6'd63);
		queue_request(CMD_READ, 16'd0, 32'sd0, 6'd0);
		queue_request(CMD_DEL, 16'd40000, 32'sd0, 6'd0);
		queue_request(CMD_ADD, 16'h5555, 32'sh5555_5555, 6'h2A);

		while (pending_requests.size() < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					// Fill the table past full, then merge into terms while full.
					if ($urandom_range(0, 1) == 1) begin
						queue_request(CMD_CLEAR, EXP_W'($urandom), COEF_W'($urandom),
							RPOS_W'($urandom));
						used_exponents.delete();
					end
					repeat (70) begin
						queue_request(CMD_ADD, EXP_W'($urandom), draw_coefficient(),
							RPOS_W'($urandom));
					end
					repeat (6) begin
						queue_request(CMD_ADD, known_exponent(), draw_coefficient(),
							RPOS_W'($urandom));
					end
				end
				2, 3, 4, 5, 6: begin
					repeat (40) begin
						pick = $urandom_range(0, 99);
						if (pick < 40) begin
							e = ($urandom_range(0, 1) == 1) ? known_exponent() : EXP_W'($urandom);
							queue_request(CMD_ADD, e, draw_coefficient(), RPOS_W'($urandom));
						end else if (pick < 60) begin
							e = ($urandom_range(0, 9) < 7) ? known_exponent() : EXP_W'($urandom);
							queue_request(CMD_DEL, e, COEF_W'($urandom), RPOS_W'($urandom));
						end else if (pick < 97) begin
							queue_request(CMD_READ, EXP_W'($urandom), COEF_W'($urandom),
								RPOS_W'($urandom));
						end else begin
							queue_request(CMD_CLEAR, EXP_W'($urandom), COEF_W'($urandom),
								RPOS_W'($urandom));
						end
					end
				end
				7: begin
					// Add a term and its negation back to back.
					repeat (10) begin
						e = ($urandom_range(0, 1) == 1) ? known_exponent() : EXP_W'($urandom);
						k = draw_coefficient();
						queue_request(CMD_ADD, e, k, RPOS_W'($urandom));
						queue_request(CMD_ADD, e, -k, RPOS_W'($urandom));
					end
				end
				8: begin
					for (p = 0; p < TERM_SLOTS; p++) begin
						queue_request(CMD_READ, EXP_W'($urandom), COEF_W'($urandom),
							RPOS_W'(p));
					end
				end
				default: begin
					repeat (15) begin
						queue_request(cmd_t'($urandom_range(0, 3)), EXP_W'($urandom),
							COEF_W'($urandom), RPOS_W'($urandom));
					end
				end
			endcase
		end
		requests_total = pending_requests.size();

		wait (arst_n === 1'b1);
		while (requests_sent < requests_total || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("[sparse_poly_term_accumulator] OK");
		end else begin
			$display("[sparse_poly_term_accumulator] ERROR");
		end
		$finish;
	end

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid            <= 1'b0;
			req_if.cmd              <= CMD_ADD;
			req_if.term_exponent    <= '0;
			req_if.term_coefficient <= '0;
			req_if.read_position    <= '0;
			send_wait               <= 0;
			requests_sent           <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				seen_req = '{cmd: cmd_t'(req_if.cmd), exponent: req_if.term_exponent,
					coefficient: req_if.term_coefficient, position: req_if.read_position};
				expected_results.push_back(apply_term_request(seen_req));
				requests_sent <= requests_sent + 1;
			end
			// Hold a request until it is taken, then wait out the drawn gap.
			if (!req_if.valid || req_if.ready) begin
				if (send_wait != 0) begin
					req_if.valid <= 1'b0;
					send_wait    <= send_wait - 1;
				end else if (pending_requests.size() != 0) begin
					next_req                 = pending_requests.pop_front();
					req_if.valid            <= 1'b1;
					req_if.cmd              <= next_req.cmd;
					req_if.term_exponent    <= next_req.exponent;
					req_if.term_coefficient <= next_req.coefficient;
					req_if.read_position    <= next_req.position;
					send_wait               <= pick_wait(requests_sent);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_wait   <= 0;
			results_seen <= 0;
		end else if (res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$write("%0t: result with no request pending: ", $realtime);
					$display("status=%0d count=%0d exp=%0d coef=%0d",
						res_if.status, res_if.count_now, res_if.read_exponent,
						res_if.read_coefficient);
				end
			end else begin
				want = expected_results.pop_front();
				if (res_if.status !== want.status || res_if.count_now !== want.count_now ||
					res_if.read_exponent !== want.read_exponent ||
					res_if.read_coefficient !== want.read_coefficient) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$write("%0t: result %0d mismatch: status %0d/%0d count %0d/%0d ",
							$realtime, results_seen, want.status, res_if.status,
							want.count_now, res_if.count_now);
						$display("exp %0d/%0d coef %0d/%0d (expected/actual)",
							want.read_exponent, res_if.read_exponent,
							want.read_coefficient, res_if.read_coefficient);
					end
				end
			end
			results_seen <= results_seen + 1;
			stall_draw    = pick_wait(results_seen);
			stall_wait   <= stall_draw;
			res_if.ready <= (stall_draw == 0);
		end else if (stall_wait != 0) begin
			stall_wait   <= stall_wait - 1;
			res_if.ready <= (stall_wait == 1);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[sparse_poly_term_accumulator] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
